// ----- rtl/scaled_glyph_scanline_renderer_defines.svh -----
// Assertion macros shared by the glyph renderer RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef SCALED_GLYPH_SCANLINE_RENDERER_DEFINES_SVH
`define SCALED_GLYPH_SCANLINE_RENDERER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SGSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgsr: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SGSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgsr: next-cycle check failed");

`endif

// ----- rtl/sgsr_pkg.sv -----
// Package for the scaled glyph scanline renderer: sizes, codes, types, helpers.
// No dependencies.
`default_nettype none

package sgsr_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int MAC_W       = 17;
  localparam int GLYPH_BASE  = 4;
  localparam logic [2:0] TOP_BIT = 3'd7;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_FG_COLOR   = 3'd0,
    REG_BG_COLOR   = 3'd1,
    REG_WIDTH      = 3'd2,
    REG_HEIGHT     = 3'd3,
    REG_FIRST_CHAR = 3'd4,
    REG_CHAR_COUNT = 3'd5,
    REG_SCALE      = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_CHECK,
    S_OFFSET,
    S_BASE,
    S_RD0,
    S_RD1,
    S_EMIT
  } state_t;

  // one multiply-add request: y = a * b + c
  typedef struct packed {
    logic             en;
    logic [MAC_W-1:0] a;
    logic [5:0]       b;
    logic [MAC_W-1:0] c;
  } mac_req_t;

  function automatic logic [1:0] eff_width(input logic [1:0] wb);
    logic [1:0] r;
    case (wb)
      2'd0:    r = 2'd1;
      2'd3:    r = 2'd2;
      default: r = wb;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] eff_scale(input logic [2:0] sc);
    logic [2:0] r;
    if (sc == 3'd0) begin
      r = 3'd1;
    end else if (sc > 3'd4) begin
      r = 3'd4;
    end else begin
      r = sc;
    end
    return r;
  endfunction

  // line / scale for scale 1..4; divide by 3 via reciprocal 171/512
  function automatic logic [6:0] row_of_line(input logic [6:0] line, input logic [2:0] sc);
    logic [15:0] prod;
    logic [6:0]  r;
    prod = 16'(line) * 16'd171;
    case (sc)
      3'd2:    r = line >> 1;
      3'd3:    r = prod[15:9];
      3'd4:    r = line >> 2;
      default: r = line;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sgsr_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module sgsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/sgsr_mac.sv -----
// Shared multiply-add unit with registered result, y = a * b + c.
// Depends on sgsr_pkg.
`default_nettype none

module sgsr_mac import sgsr_pkg::*; (
  input  wire logic             clk,
  input  wire mac_req_t         req,
  output logic      [MAC_W-1:0] y
);

  logic [MAC_W+5:0] prod;

  assign prod = (MAC_W+6)'(req.a) * (MAC_W+6)'(req.b);

  always_ff @(posedge clk) begin
    if (req.en) begin
      y <= MAC_W'(prod + (MAC_W+6)'(req.c));
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scaled_glyph_scanline_renderer.sv -----
// Scaled glyph scanline renderer top level: sequencer, glyph store, pixel output.
// Depends on sgsr_pkg, sgsr_mac, sgsr_ram and the assertion macro header.
//
// A load (operation 0) writes one store byte in the accept cycle and leaves
// busy low, so loads can be issued every cycle. A render (operation 1) holds
// busy high while it runs the limit, check, offset and base steps and two store
// reads and then emits width_bytes*8*scale pixels; a request rejected for its
// character or line skips the offset, address and read steps, one rejected
// for store overflow skips the reads. The steps use one shared multiply-add
// unit, used for the line limit, glyph row offset and byte address in turn,
// followed by two reads of the single-port glyph store. Pixels come out one
// per cycle on strobe, each valid for exactly that cycle; the receiver cannot
// stall them. A new start is taken in the cycle the final pixel is on the ports.
`default_nettype none

`include "scaled_glyph_scanline_renderer_defines.svh"

module scaled_glyph_scanline_renderer import sgsr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [11:0] store_address,
  input  wire logic [7:0]  store_byte,
  input  wire logic [7:0]  char_code,
  input  wire logic [6:0]  scaled_line,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             strobe,
  output logic      [15:0] pixel_color,
  output logic             last_pixel,
  output logic             bad_request
);

  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic [1:0]  glyph_width_bytes;
  logic [5:0]  glyph_height;
  logic [7:0]  first_char;
  logic [8:0]  char_count;
  logic [2:0]  scale;

  state_t state, state_next;

  logic [7:0]       code_q;
  logic [6:0]       line_q;
  logic             bad_q;
  logic [MAC_W-1:0] base_q;
  logic [7:0]       byte0;
  logic [7:0]       byte1;
  logic [3:0]       col;
  logic [1:0]       rep;

  logic                accept;
  logic                load_we;
  logic [1:0]          wb_eff;
  logic [2:0]          sc_eff;
  logic [1:0]          sc_m1;
  logic [3:0]          col_last;
  logic [7:0]          idx;
  logic [6:0]          row;
  logic                bad_chk;
  logic [MAC_W-1:0]    end_addr;
  logic                ovf;
  logic                emit_last;
  logic [7:0]          sel_byte;
  logic                pix_set;
  mac_req_t            mac_req;
  logic [MAC_W-1:0]    acc;
  logic [STORE_AW-1:0] ram_addr;
  logic [7:0]          ram_rdata;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign load_we = accept && (op_t'(operation) == OP_LOAD)
                   && (32'(store_address) < STORE_BYTES);

  assign wb_eff   = eff_width(glyph_width_bytes);
  assign sc_eff   = eff_scale(scale);
  assign sc_m1    = 2'(sc_eff - 3'd1);
  assign col_last = (wb_eff == 2'd2) ? 4'd15 : 4'd7;
  assign idx      = code_q - first_char;
  assign row      = row_of_line(line_q, sc_eff);
  assign bad_chk  = (code_q < first_char) || ({1'b0, idx} >= char_count)
                    || (MAC_W'(line_q) >= acc);
  assign end_addr = acc + MAC_W'(wb_eff) - MAC_W'(1);
  assign ovf      = (32'(end_addr) >= STORE_BYTES);

  assign emit_last = (col == col_last) && (rep == sc_m1);
  assign sel_byte  = col[3] ? byte1 : byte0;
  assign pix_set   = !bad_q && sel_byte[TOP_BIT - col[2:0]];

  sgsr_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .y   (acc)
  );

  sgsr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata (store_byte),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color          <= 16'hFFFF;
      bg_color          <= 16'h0000;
      glyph_width_bytes <= 2'd1;
      glyph_height      <= 6'd12;
      first_char        <= 8'd32;
      char_count        <= 9'd95;
      scale             <= 3'd1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FG_COLOR:   fg_color          <= cfg_data;
        REG_BG_COLOR:   bg_color          <= cfg_data;
        REG_WIDTH:      glyph_width_bytes <= cfg_data[1:0];
        REG_HEIGHT:     glyph_height      <= cfg_data[5:0];
        REG_FIRST_CHAR: first_char        <= cfg_data[7:0];
        REG_CHAR_COUNT: char_count        <= cfg_data[8:0];
        REG_SCALE:      scale             <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && (op_t'(operation) == OP_RENDER)) state_next = S_LIMIT;
      S_LIMIT:  state_next = S_CHECK;
      S_CHECK:  state_next = bad_chk ? S_EMIT : S_OFFSET;
      S_OFFSET: state_next = S_BASE;
      S_BASE:   state_next = ovf ? S_EMIT : S_RD0;
      S_RD0:    state_next = S_RD1;
      S_RD1:    state_next = S_EMIT;
      S_EMIT:   if (emit_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // unit operands and store address per step
  always_comb begin
    mac_req  = '0;
    ram_addr = STORE_AW'(store_address);
    unique case (state)
      S_LIMIT: begin
        mac_req.en = 1'b1;
        mac_req.a  = MAC_W'(sc_eff);
        mac_req.b  = glyph_height;
        mac_req.c  = '0;
      end
      S_CHECK: begin
        mac_req.en = 1'b1;
        mac_req.a  = MAC_W'(idx);
        mac_req.b  = glyph_height;
        mac_req.c  = MAC_W'(row);
      end
      S_OFFSET: begin
        mac_req.en = 1'b1;
        mac_req.a  = acc;
        mac_req.b  = 6'(wb_eff);
        mac_req.c  = MAC_W'(GLYPH_BASE);
      end
      S_BASE:  ram_addr = STORE_AW'(acc);
      S_RD0:   ram_addr = STORE_AW'(base_q + MAC_W'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      col    <= '0;
      rep    <= '0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_EMIT);
      if (state == S_IDLE) begin
        col <= '0;
        rep <= '0;
      end else if (state == S_EMIT) begin
        if (rep == sc_m1) begin
          rep <= '0;
          col <= col + 4'd1;
        end else begin
          rep <= rep + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op_t'(operation) == OP_RENDER)) begin
      code_q <= char_code;
      line_q <= scaled_line;
      bad_q  <= 1'b0;
    end
    if ((state == S_CHECK) && bad_chk) begin
      bad_q <= 1'b1;
    end
    if (state == S_BASE) begin
      base_q <= acc;
      if (ovf) begin
        bad_q <= 1'b1;
      end
    end
    if (state == S_RD0) begin
      byte0 <= ram_rdata;
    end
    if (state == S_RD1) begin
      byte1 <= ram_rdata;
    end
    pixel_color <= pix_set ? fg_color : bg_color;
    last_pixel  <= emit_last;
    bad_request <= bad_q;
  end

  `SGSR_ASSERT_NEXT(a_emit_gives_beat, state == S_EMIT, strobe)
  `SGSR_ASSERT_SAME(a_mid_line_stays_busy, strobe && !last_pixel, state == S_EMIT)
  `SGSR_ASSERT_SAME(a_bad_is_background, strobe && bad_request, pixel_color == bg_color)

endmodule

`default_nettype wire

// ----- tb/sv/scaled_glyph_scanline_renderer_test.sv -----
// Testbench for scaled_glyph_scanline_renderer: directed and random glyph loads and renders,
// each pixel beat checked against a built-in line predictor. Depends on sgsr_pkg and the RTL.
`default_nettype none

module scaled_glyph_scanline_renderer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgsr_pkg::*;

  typedef struct packed {
    logic [15:0] color;
    logic        last;
    logic        bad;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [11:0] store_address;
  logic [7:0]  store_byte;
  logic [7:0]  char_code;
  logic [6:0]  scaled_line;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        strobe;
  logic [15:0] pixel_color;
  logic        last_pixel;
  logic        bad_request;

  logic [15:0] fg_reg;
  logic [15:0] bg_reg;
  logic [1:0]  width_reg;
  logic [5:0]  height_reg;
  logic [7:0]  first_reg;
  logic [8:0]  count_reg;
  logic [2:0]  scale_reg;
  logic [7:0]  font_mirror [STORE_BYTES];
  bit          font_written [STORE_BYTES];

  pixel_t expected_pixels [$];
  int     mismatch_count = 0;

  scaled_glyph_scanline_renderer u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .store_address(store_address),
    .store_byte   (store_byte),
    .char_code    (char_code),
    .scaled_line  (scaled_line),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .pixel_color  (pixel_color),
    .last_pixel   (last_pixel),
    .bad_request  (bad_request)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch @%0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && strobe !== 1'b0) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel beat with none expected, color %h", pixel_color));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_color !== want.color) begin
          report_mismatch($sformatf("pixel_color %h, want %h", pixel_color, want.color));
        end
        if (last_pixel !== want.last) begin
          report_mismatch($sformatf("last_pixel %b, want %b", last_pixel, want.last));
        end
        if (bad_request !== want.bad) begin
          report_mismatch($sformatf("bad_request %b, want %b", bad_request, want.bad));
        end
      end
    end
  end

  function automatic int unsigned width_now();
    int unsigned w;
    case (width_reg)
      2'd0:    w = 1;
      2'd3:    w = 2;
      default: w = width_reg;
    endcase
    return w;
  endfunction

  function automatic int unsigned scale_now();
    int unsigned s;
    if (scale_reg == 3'd0) begin
      s = 1;
    end else if (scale_reg > 3'd4) begin
      s = 4;
    end else begin
      s = scale_reg;
    end
    return s;
  endfunction

  // store address of the font row a render reads; returns 0 when the render is rejected
  function automatic bit find_row(input logic [7:0] code, input logic [6:0] line,
                                  output int unsigned base);
    int unsigned c, l, f, wb, sc, h;
    c = code;
    l = line;
    f = first_reg;
    h = height_reg;
    wb = width_now();
    sc = scale_now();
    base = 0;
    if (c < f || c - f >= count_reg) return 1'b0;
    if (l >= h * sc) return 1'b0;
    base = GLYPH_BASE + (c - f) * wb * h + (l / sc) * wb;
    if (base + wb - 1 >= STORE_BYTES) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_scanline(input logic [7:0] code, input logic [6:0] line);
    int unsigned base, wb, sc, npix, col;
    bit          ok;
    logic [7:0]  row_byte;
    pixel_t      want;
    ok = find_row(code, line, base);
    wb = width_now();
    sc = scale_now();
    npix = wb * 8 * sc;
    for (int unsigned p = 0; p < npix; p++) begin
      col = p / sc;
      row_byte = 8'h00;
      if (ok) begin
        row_byte = font_mirror[base + col / 8];
      end
      want.color = row_byte[3'(7 - col % 8)] ? fg_reg : bg_reg;
      want.last  = (p == npix - 1);
      want.bad   = !ok;
      expected_pixels.push_back(want);
    end
  endfunction

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    pause(4);
  endtask

  task automatic send_request(input op_t op, input logic [11:0] addr, input logic [7:0] data,
                              input logic [7:0] code, input logic [6:0] line);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    store_address = addr;
    store_byte = data;
    char_code = code;
    scaled_line = line;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_LOAD) begin
      font_mirror[addr] = data;
      font_written[addr] = 1'b1;
    end else begin
      predict_scanline(code, line);
    end
  endtask

  task automatic load_byte(input logic [11:0] addr, input logic [7:0] data);
    send_request(OP_LOAD, addr, data, 8'($urandom), 7'($urandom));
  endtask

  // fills any unwritten byte of the row first, so no render reads an empty entry
  task automatic render_line(input logic [7:0] code, input logic [6:0] line);
    int unsigned base;
    if (find_row(code, line, base)) begin
      for (int unsigned b = 0; b < width_now(); b++) begin
        if (!font_written[base + b]) begin
          load_byte(12'(base + b), 8'($urandom));
        end
      end
    end
    send_request(OP_RENDER, 12'($urandom), 8'($urandom), code, line);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
    wait_idle();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data = 16'($urandom);
    case (idx)
      REG_FG_COLOR:   fg_reg = value;
      REG_BG_COLOR:   bg_reg = value;
      REG_WIDTH:      width_reg = value[1:0];
      REG_HEIGHT:     height_reg = value[5:0];
      REG_FIRST_CHAR: first_reg = value[7:0];
      REG_CHAR_COUNT: count_reg = value[8:0];
      REG_SCALE:      scale_reg = value[2:0];
      default: ;
    endcase
  endtask

  task automatic random_settings();
    logic [15:0] noise;
    noise = 16'($urandom);
    write_register(REG_FG_COLOR, 16'($urandom));
    write_register(REG_BG_COLOR, 16'($urandom));
    write_register(REG_WIDTH, {noise[15:2], 2'($urandom_range(0, 5) < 4
                                               ? $urandom_range(1, 2) : $urandom_range(0, 3))});
    write_register(REG_HEIGHT, {noise[15:6], 6'($urandom_range(0, 15) == 0
                                                ? 0 : $urandom_range(1, 32))});
    write_register(REG_FIRST_CHAR, {noise[15:8], 8'($urandom)});
    write_register(REG_CHAR_COUNT, {noise[15:9], 9'($urandom_range(0, 3) == 0
                                                   ? 256 : $urandom_range(1, 60))});
    write_register(REG_SCALE, {noise[15:3], 3'($urandom_range(0, 5) < 4
                                               ? $urandom_range(1, 4) : $urandom_range(0, 7))});
  endtask

  task automatic test_default_font();
    load_byte(12'd400, 8'h80);
    load_byte(12'd411, 8'h01);
    load_byte(12'd0, 8'hFF);
    load_byte(12'd4095, 8'h00);
    render_line(8'd65, 7'd0);
    render_line(8'd65, 7'd11);
    render_line(8'd65, 7'd12);
    render_line(8'd31, 7'd0);
    wait_idle();
    render_line(8'd127, 7'd3);
    render_line(8'd126, 7'd5);
    render_line(8'd32, 7'd0);
  endtask

  task automatic test_register_extremes();
    write_register(REG_FG_COLOR, 16'hF800);
    write_register(REG_BG_COLOR, 16'h07E0);
    write_register(REG_WIDTH, 16'd2);
    write_register(REG_HEIGHT, 16'd32);
    write_register(REG_FIRST_CHAR, 16'd0);
    write_register(REG_CHAR_COUNT, 16'd256);
    write_register(REG_SCALE, 16'd4);
    render_line(8'd0, 7'd0);
    render_line(8'd0, 7'd127);
    render_line(8'd63, 7'd119);
    render_line(8'd63, 7'd120);
    render_line(8'd255, 7'd127);

    write_register(REG_WIDTH, 16'd3);
    write_register(REG_SCALE, 16'hFFFF);
    write_register(REG_HEIGHT, 16'd1);
    write_register(REG_FIRST_CHAR, 16'd255);
    write_register(REG_CHAR_COUNT, 16'd1);
    render_line(8'd255, 7'd0);
    render_line(8'd255, 7'd4);
    render_line(8'd254, 7'd0);

    write_register(REG_WIDTH, 16'd0);
    write_register(REG_SCALE, 16'd0);
    write_register(REG_HEIGHT, 16'd0);
    render_line(8'd255, 7'd0);

    write_register(REG_SCALE, 16'd5);
    write_register(REG_HEIGHT, 16'd12);
    write_register(REG_CHAR_COUNT, 16'd0);
    render_line(8'd255, 7'd0);

    write_register(REG_SCALE, 16'd3);
    write_register(REG_HEIGHT, 16'd5);
    write_register(REG_FIRST_CHAR, 16'd0);
    write_register(REG_CHAR_COUNT, 16'd256);
    write_register(REG_FG_COLOR, 16'h0000);
    write_register(REG_BG_COLOR, 16'hFFFF);
    render_line(8'd10, 7'd14);
    render_line(8'd10, 7'd15);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int beats);
    int unsigned lim, hi, kind;
    logic [7:0]  code;
    logic [6:0]  line;
    random_settings();
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        pause($urandom_range(0, 3) == 0 ? $urandom_range(7, 72) : $urandom_range(1, 6));
      end
      if ($urandom_range(0, 99) == 0) begin
        wait_idle();
      end
      lim = height_reg * scale_now();
      hi = first_reg + count_reg - 1;
      if (hi > 255) hi = 255;
      kind = $urandom_range(0, 99);
      if (kind < 60 && count_reg != 0 && lim != 0) begin
        code = 8'($urandom_range(first_reg, hi));
        line = 7'($urandom_range(0, lim - 1));
        render_line(code, line);
      end else if (kind < 75) begin
        load_byte(12'($urandom), 8'($urandom));
      end else if (kind < 88) begin
        render_line(8'($urandom), 7'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       code = first_reg - 8'd1;
          1:       code = 8'(hi + 1);
          2:       code = first_reg;
          default: code = 8'(hi);
        endcase
        case ($urandom_range(0, 3))
          0:       line = 7'(lim);
          1:       line = 7'(lim - 1);
          2:       line = 7'd0;
          default: line = 7'd127;
        endcase
        render_line(code, line);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_LOAD;
    store_address = '0;
    store_byte = '0;
    char_code = '0;
    scaled_line = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FG_COLOR;
    cfg_data = '0;
    fg_reg = 16'hFFFF;
    bg_reg = 16'h0000;
    width_reg = 2'd1;
    height_reg = 6'd12;
    first_reg = 8'd32;
    count_reg = 9'd95;
    scale_reg = 3'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_font();
    test_register_extremes();
    test_random_traffic(0, 36);
    test_random_traffic(55, 36);
    test_random_traffic(7, 36);
    test_random_traffic(0, 36);

    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
